>>> src/chft_pkg.sv
package chft_pkg;

    localparam int CORDIC_ITERATIONS_DEF   = 16;
    localparam int ANGLE_FRACTION_BITS_DEF = 6;

    localparam int RAW_W    = 16;
    localparam int CAL_A_W  = 21;
    localparam int SCALE_W  = 16;
    localparam int PROD_W   = 37;
    localparam int CORDIC_W = 40;
    localparam int ZQ_W     = 26;
    localparam int ZQ_FRAC  = 16;
    localparam int ATAN_W   = 22;
    localparam int ATAN_N   = 24;
    localparam int OUT_W    = 15;
    localparam int ALPHA_W  = 9;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    localparam logic signed [ZQ_W-1:0] QUARTER_Q = ZQ_W'(90 <<< ZQ_FRAC);

    localparam logic signed [CFG_W-1:0] OFFSET_X_RST = -16'sd56;
    localparam logic signed [CFG_W-1:0] OFFSET_Y_RST = 16'sd136;
    localparam logic [CFG_W-1:0]        SCALE_X_RST  = 16'd17203;
    localparam logic [CFG_W-1:0]        SCALE_Y_RST  = 16'd16220;
    localparam logic signed [CFG_W-1:0] HOFF_RST     = -16'sd5665;
    localparam logic [ALPHA_W-1:0]      ALPHA_RST    = 9'd102;
    localparam logic [ALPHA_W-1:0]      ALPHA_MAX    = 9'd256;
    localparam logic [OUT_W-1:0]        PBOOT_RST    = 15'd11520;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X       = 3'd0,
        CFG_OFFSET_Y       = 3'd1,
        CFG_SCALE_X        = 3'd2,
        CFG_SCALE_Y        = 3'd3,
        CFG_HEADING_OFFSET = 3'd4,
        CFG_FILTER_ALPHA   = 3'd5,
        CFG_POSITION_BOOT  = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAL,
        ST_ROT,
        ST_WRAP,
        ST_FILT,
        ST_UPD,
        ST_OUT
    } t_state;

    function automatic logic [ATAN_W-1:0] f_atan(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/chft_mul.sv
module chft_mul
    import chft_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [CAL_A_W-1:0] i_a,
    input  logic [SCALE_W-1:0]        i_b,
    output logic signed [PROD_W-1:0]  o_p,
    output logic                      o_done
);

    localparam int CNT_W = $clog2(SCALE_W);

    logic signed [PROD_W-1:0] r_acc;
    logic signed [PROD_W-1:0] r_a;
    logic [SCALE_W-1:0]       r_b;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_busy;
    logic                     r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SCALE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= PROD_W'(i_a);
            r_b   <= i_b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a <<< 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_p    = r_acc;
    assign o_done = r_done;

endmodule

>>> src/chft_cordic.sv
module chft_cordic
    import chft_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [CORDIC_W-1:0] i_x,
    input  logic signed [CORDIC_W-1:0] i_y,
    output logic signed [ZQ_W-1:0]     o_z,
    output logic                       o_done
);

    localparam int RUN  = (CORDIC_ITERATIONS > ATAN_N) ? ATAN_N : CORDIC_ITERATIONS;
    localparam int IT_W = $clog2(RUN);

    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [ZQ_W-1:0]     r_z;
    logic [IT_W-1:0]            r_it;
    logic                       r_busy;
    logic                       r_done;

    logic signed [CORDIC_W-1:0] w_dx;
    logic signed [CORDIC_W-1:0] w_dy;
    logic signed [ZQ_W-1:0]     w_atan;

    assign w_dx   = r_y >>> r_it;
    assign w_dy   = r_x >>> r_it;
    assign w_atan = ZQ_W'(f_atan(5'(r_it)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_it   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_it <= '0;
                if (i_x == '0 && i_y == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_it <= r_it + 1'b1;
                if (r_it == IT_W'(RUN - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (i_x == '0 && i_y == '0) begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= '0;
            end else if (i_x < 0 && i_y >= 0) begin
                r_x <= i_y;
                r_y <= -i_x;
                r_z <= QUARTER_Q;
            end else if (i_x < 0) begin
                r_x <= -i_y;
                r_y <= i_x;
                r_z <= -QUARTER_Q;
            end else begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end else begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end
        end
    end

    assign o_z    = r_z;
    assign o_done = r_done;

endmodule

>>> src/compass_heading_filter_and_turn_tracker_unit.sv
// Good read: the transaction passes through the bit-serial calibration multipliers, the CORDIC
// iterations and the wrap steps, then the handoffs, filter, update and output load into the
// result register. A failed read goes straight to the output load. A zero vector skips the
// CORDIC iterations. A new transaction is accepted only in idle, once the previous result has
// been loaded into the output register; that load waits for m_axis_tready while a result is held.
// Reset (synchronous, active low): registers to defaults, headings 0, position to position_boot.
module compass_heading_filter_and_turn_tracker_unit
    import chft_pkg::*;
#(
    parameter int CORDIC_ITERATIONS   = CORDIC_ITERATIONS_DEF,
    parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // mag_x, mag_y
    input  logic [0:0]            s_axis_tuser,   // read_ok
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // smooth_heading, instant_heading, turn_position
    output logic [0:0]            m_axis_tuser,   // sensor_healthy
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int FULL = 360 << ANGLE_FRACTION_BITS;
    localparam int HALF = 180 << ANGLE_FRACTION_BITS;
    localparam int UW   = $clog2(FULL + 1);
    localparam int SW   = ((UW > CFG_W) ? UW : CFG_W) + 3;
    localparam int PW   = SW + ALPHA_W + 1;
    localparam int SH   = ZQ_FRAC - ANGLE_FRACTION_BITS;
    localparam int POS_RST = (int'(PBOOT_RST) > FULL) ? FULL : int'(PBOOT_RST);

    t_state r_state;
    t_state n_state;

    logic signed [CFG_W-1:0] r_off_x;
    logic signed [CFG_W-1:0] r_off_y;
    logic [CFG_W-1:0]        r_scale_x;
    logic [CFG_W-1:0]        r_scale_y;
    logic signed [CFG_W-1:0] r_hoff;
    logic [ALPHA_W-1:0]      r_alpha;
    logic [OUT_W-1:0]        r_pboot;

    logic [UW-1:0] r_raw;
    logic [UW-1:0] r_ema;
    logic [UW-1:0] r_prev;
    logic [UW-1:0] r_pos;
    logic          r_ema_seed;
    logic          r_trk_seed;
    logic          r_healthy;

    logic signed [SW-1:0] r_sum;
    logic signed [PW-1:0] r_prod;
    logic signed [SW-1:0] r_pos_sum;

    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic                  r_m_user;

    logic w_accept;
    logic w_mul_start;
    logic w_cor_start;
    logic w_out_free;
    logic w_in_range;

    logic signed [CAL_A_W-1:0]  w_ax;
    logic signed [CAL_A_W-1:0]  w_ay;
    logic signed [PROD_W-1:0]   w_px;
    logic signed [PROD_W-1:0]   w_py;
    logic                       w_mx_done;
    logic                       w_my_done;
    logic signed [ZQ_W-1:0]     w_z;
    logic                       w_cor_done;
    logic signed [ZQ_W-1:0]     w_ang;
    logic [UW-1:0]              w_boot;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_in_range = (r_sum >= 0) && (r_sum < SW'(FULL));

    assign w_ax = (CAL_A_W'($signed(s_axis_tdata[15:0])) <<< 4) - CAL_A_W'(r_off_x);
    assign w_ay = (CAL_A_W'($signed(s_axis_tdata[31:16])) <<< 4) - CAL_A_W'(r_off_y);

    assign w_ang  = (w_z + ZQ_W'(1 <<< (SH - 1))) >>> SH;
    assign w_boot = (int'(r_pboot) > FULL) ? UW'(FULL) : UW'(r_pboot);

    chft_mul u_mul_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ax),
        .i_b     (r_scale_x),
        .o_p     (w_px),
        .o_done  (w_mx_done)
    );

    chft_mul u_mul_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ay),
        .i_b     (r_scale_y),
        .o_p     (w_py),
        .o_done  (w_my_done)
    );

    chft_cordic #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_x     (CORDIC_W'(w_px)),
        .i_y     (-CORDIC_W'(w_py)),
        .o_z     (w_z),
        .o_done  (w_cor_done)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = s_axis_tuser[0] ? ST_CAL : ST_OUT;
                end
            end
            ST_CAL:  if (w_mx_done) n_state = ST_ROT;
            ST_ROT:  if (w_cor_done) n_state = ST_WRAP;
            ST_WRAP: if (w_in_range) n_state = ST_FILT;
            ST_FILT: n_state = ST_UPD;
            ST_UPD:  n_state = ST_OUT;
            ST_OUT:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_mul_start   = 1'b0;
        w_cor_start   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_mul_start   = s_axis_tvalid && s_axis_tuser[0];
            end
            ST_CAL:  w_cor_start = w_mx_done;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x   <= OFFSET_X_RST;
            r_off_y   <= OFFSET_Y_RST;
            r_scale_x <= SCALE_X_RST;
            r_scale_y <= SCALE_Y_RST;
            r_hoff    <= HOFF_RST;
            r_alpha   <= ALPHA_RST;
            r_pboot   <= PBOOT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_OFFSET_X:       r_off_x   <= i_cfg_data;
                CFG_OFFSET_Y:       r_off_y   <= i_cfg_data;
                CFG_SCALE_X:        r_scale_x <= i_cfg_data;
                CFG_SCALE_Y:        r_scale_y <= i_cfg_data;
                CFG_HEADING_OFFSET: r_hoff    <= i_cfg_data;
                CFG_FILTER_ALPHA:   r_alpha   <= i_cfg_data[ALPHA_W-1:0];
                CFG_POSITION_BOOT:  r_pboot   <= i_cfg_data[OUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [SW-1:0]     v_e;
        if (!i_rst_n) begin
            r_raw      <= '0;
            r_ema      <= '0;
            r_prev     <= '0;
            r_pos      <= UW'(POS_RST);
            r_ema_seed <= 1'b0;
            r_trk_seed <= 1'b0;
            r_healthy  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && !s_axis_tuser[0]) begin
                        r_healthy <= 1'b0;
                    end
                end
                ST_WRAP: begin
                    if (w_in_range) begin
                        r_raw <= UW'(r_sum);
                    end
                end
                ST_UPD: begin
                    r_healthy <= 1'b1;
                    if (!r_ema_seed) begin
                        r_ema      <= r_raw;
                        r_ema_seed <= 1'b1;
                    end else begin
                        v_e = SW'(r_ema) + SW'((r_prod + PW'(128)) >>> 8);
                        if (v_e < 0) begin
                            v_e = v_e + SW'(FULL);
                        end else if (v_e >= SW'(FULL)) begin
                            v_e = v_e - SW'(FULL);
                        end
                        r_ema <= UW'(v_e);
                    end
                    r_prev <= r_raw;
                    if (!r_trk_seed) begin
                        r_pos      <= w_boot;
                        r_trk_seed <= 1'b1;
                    end else if (r_pos_sum < 0) begin
                        r_pos <= '0;
                    end else if (r_pos_sum > SW'(FULL)) begin
                        r_pos <= UW'(FULL);
                    end else begin
                        r_pos <= UW'(r_pos_sum);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [SW-1:0] v_de;
        logic signed [SW-1:0] v_dp;
        logic [ALPHA_W-1:0]   v_alpha;
        v_de    = SW'(r_raw) - SW'(r_ema);
        v_dp    = SW'(r_raw) - SW'(r_prev);
        v_alpha = (r_alpha > ALPHA_MAX) ? ALPHA_MAX : r_alpha;
        if (v_de > SW'(HALF)) begin
            v_de = v_de - SW'(FULL);
        end else if (v_de < -SW'(HALF)) begin
            v_de = v_de + SW'(FULL);
        end
        if (v_dp > SW'(HALF)) begin
            v_dp = v_dp - SW'(FULL);
        end else if (v_dp < -SW'(HALF)) begin
            v_dp = v_dp + SW'(FULL);
        end
        case (r_state)
            ST_ROT: begin
                if (w_cor_done) begin
                    r_sum <= SW'(w_ang) + SW'(r_hoff);
                end
            end
            ST_WRAP: begin
                if (r_sum < 0) begin
                    r_sum <= r_sum + SW'(FULL);
                end else if (r_sum >= SW'(FULL)) begin
                    r_sum <= r_sum - SW'(FULL);
                end
            end
            ST_FILT: begin
                r_prod    <= PW'($signed({1'b0, v_alpha})) * PW'(v_de);
                r_pos_sum <= SW'(r_pos) + v_dp;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            r_m_data <= {3'b000, OUT_W'(r_pos), OUT_W'(r_raw), OUT_W'(r_ema)};
            r_m_user <= r_healthy;
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data;
    assign m_axis_tuser[0] = r_m_user;

    a_fail_drops_health: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !s_axis_tuser[0]) |=> !r_healthy)
        else $error("failed read left health set");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= UW'(FULL))
        else $error("turn position out of range");

    a_raw_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_raw < UW'(FULL))
        else $error("heading out of range");

    a_seeds_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ema_seed == r_trk_seed)
        else $error("filter and tracker seeding diverged");

    a_mul_done_in_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mx_done |-> (r_state == ST_CAL && w_my_done))
        else $error("multiplier finished outside calibration");

endmodule

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import chft_pkg::*;

    localparam int FULL_U = 23040;
    localparam int HALF_U = 11520;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    typedef struct packed {
        logic [14:0] smooth;
        logic [14:0] inst;
        logic [14:0] turn;
        logic        healthy;
    } t_heading;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic                  ok;
        logic signed [15:0]    mx;
        logic signed [15:0]    my;
        logic                  typed;
        t_heading              want;
        logic [CFG_IDX_W-1:0]  addr;
        logic [CFG_W-1:0]      data;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    compass_heading_filter_and_turn_tracker_unit dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor copy of registers and state
    logic signed [15:0] off_x = -16'sd56, off_y = 16'sd136, hdg_off = -16'sd5665;
    logic [15:0]        scl_x = 16'd17203, scl_y = 16'd16220;
    logic [8:0]         alpha_r = 9'd102;
    logic [14:0]        pboot_r = 15'd11520;
    longint raw_hdg = 0, ema_hdg = 0, prev_hdg = 0, pos_acc = 11520;
    bit     ema_live = 0, trk_live = 0, healthy_r = 0;

    t_heading heading_q[$];
    int errors = 0, n_items = 0, n_results = 0, n_cfg = 0;
    int snd_idle = 0, rcv_idle = 0;
    t_row rows[$];

    const int atan_tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    function automatic longint wrap_full(longint v);
        longint r;
        r = v % FULL_U;
        return (r < 0) ? r + FULL_U : r;
    endfunction

    function automatic longint wrap_delta(longint d);
        if (d > HALF_U) d -= FULL_U;
        if (d < -HALF_U) d += FULL_U;
        return d;
    endfunction

    function automatic longint boot_pos();
        return (pboot_r > FULL_U) ? FULL_U : longint'(pboot_r);
    endfunction

    function automatic longint cordic_angle(longint x, longint y);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = y; y = -x; x = t; z = 90 <<< 16;
            end else begin
                t = y; y = x; x = -t; z = -(90 <<< 16);
            end
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += atan_tab[i];
            end else begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        return z;
    endfunction

    function automatic t_heading predict_heading(logic ok, logic signed [15:0] mx,
                                                 logic signed [15:0] my);
        longint cx, cy, ang, alpha, d, p;
        t_heading r;
        if (ok) begin
            cx = (longint'(mx) * 16 - longint'(off_x)) * longint'(scl_x);
            cy = (longint'(my) * 16 - longint'(off_y)) * longint'(scl_y);
            ang = (cordic_angle(cx, -cy) + (1 <<< 9)) >>> 10;
            alpha = (alpha_r > 256) ? 256 : longint'(alpha_r);
            raw_hdg = wrap_full(ang + longint'(hdg_off));
            healthy_r = 1;
            if (!ema_live) begin
                ema_hdg = raw_hdg;
                ema_live = 1;
            end else begin
                d = wrap_delta(raw_hdg - ema_hdg);
                ema_hdg = wrap_full(ema_hdg + ((alpha * d + 128) >>> 8));
            end
            if (!trk_live) begin
                prev_hdg = raw_hdg;
                pos_acc = boot_pos();
                trk_live = 1;
            end else begin
                p = pos_acc + wrap_delta(raw_hdg - prev_hdg);
                if (p < 0) p = 0;
                if (p > FULL_U) p = FULL_U;
                pos_acc = p;
                prev_hdg = raw_hdg;
            end
        end else begin
            healthy_r = 0;
        end
        r.smooth = ema_hdg[14:0];
        r.inst = raw_hdg[14:0];
        r.turn = pos_acc[14:0];
        r.healthy = healthy_r;
        return r;
    endfunction

    task automatic drain();
        while (heading_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] addr, logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_cfg++;
        case (addr)
            CFG_OFFSET_X:       off_x = data;
            CFG_OFFSET_Y:       off_y = data;
            CFG_SCALE_X:        scl_x = data;
            CFG_SCALE_Y:        scl_y = data;
            CFG_HEADING_OFFSET: hdg_off = data;
            CFG_FILTER_ALPHA:   alpha_r = data[8:0];
            CFG_POSITION_BOOT:  pboot_r = data[14:0];
            default: ;
        endcase
    endtask

    task automatic send_reading(logic ok, logic signed [15:0] mx, logic signed [15:0] my,
                                logic typed, t_heading want);
        t_heading h;
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {my, mx};
        s_axis_tuser <= ok;
        do @(posedge i_clk); while (!s_axis_tready);
        h = predict_heading(ok, mx, my);
        heading_q.push_back(typed ? want : h);
        n_items++;
    endtask

    function automatic t_row item_row(logic ok, int mx, int my);
        t_row r;
        r = '{kind: ROW_ITEM, ok: ok, mx: mx[15:0], my: my[15:0], typed: 0,
              want: '0, addr: '0, data: '0};
        return r;
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] addr, int data);
        t_row r;
        r = '{kind: ROW_CFG, ok: 0, mx: '0, my: '0, typed: 0, want: '0,
              addr: addr, data: data[15:0]};
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_heading got, exp_h;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle);
            if (m_axis_tvalid && m_axis_tready) begin
                got.smooth = m_axis_tdata[14:0];
                got.inst = m_axis_tdata[29:15];
                got.turn = m_axis_tdata[44:30];
                got.healthy = m_axis_tuser[0];
                n_results++;
                if (heading_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result %p", $time, got);
                end else begin
                    exp_h = heading_q.pop_front();
                    if (got.smooth !== exp_h.smooth) begin
                        errors++;
                        $display("%0t smooth_heading exp %0d got %0d", $time,
                                 exp_h.smooth, got.smooth);
                    end
                    if (got.inst !== exp_h.inst) begin
                        errors++;
                        $display("%0t instant_heading exp %0d got %0d", $time,
                                 exp_h.inst, got.inst);
                    end
                    if (got.turn !== exp_h.turn) begin
                        errors++;
                        $display("%0t turn_position exp %0d got %0d", $time,
                                 exp_h.turn, got.turn);
                    end
                    if (got.healthy !== exp_h.healthy) begin
                        errors++;
                        $display("%0t sensor_healthy exp %0d got %0d", $time,
                                 exp_h.healthy, got.healthy);
                    end
                end
            end
        end
    end

    initial begin
        #4ms;
        $display("timeout at %0t", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_row r;
        int mode;
        rows.push_back(item_row(0, 0, 0));
        rows[0].typed = 1;
        rows[0].want = '{smooth: 15'd0, inst: 15'd0, turn: 15'd11520, healthy: 1'b0};
        rows.push_back(cfg_row(CFG_POSITION_BOOT, 32767));
        rows.push_back(item_row(1, 32767, 32767));
        rows.push_back(item_row(1, -32768, -32768));
        rows.push_back(item_row(1, 32767, -32768));
        rows.push_back(item_row(1, -32768, 32767));
        rows.push_back(item_row(0, -1, -1));
        for (int k = 0; k < 6; k++) rows.push_back(item_row(1, 1000 - 400 * k, 300 * k - 900));
        rows.push_back(cfg_row(CFG_OFFSET_X, 0));
        rows.push_back(cfg_row(CFG_OFFSET_Y, 0));
        rows.push_back(cfg_row(CFG_FILTER_ALPHA, 511));
        rows.push_back(cfg_row(CFG_HEADING_OFFSET, 32767));
        rows.push_back(cfg_row(CFG_SPARE_IDX, 12345));
        rows.push_back(item_row(1, 0, 0));
        rows.push_back(item_row(1, 0, 100));
        rows.push_back(cfg_row(CFG_HEADING_OFFSET, -32768));
        rows.push_back(cfg_row(CFG_FILTER_ALPHA, 0));
        rows.push_back(cfg_row(CFG_SCALE_X, 65535));
        rows.push_back(cfg_row(CFG_SCALE_Y, 0));
        rows.push_back(item_row(1, -100, 0));
        rows.push_back(item_row(1, 100, -5));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle = 17;
        rcv_idle = 77;
        foreach (rows[k]) begin
            r = rows[k];
            if (r.kind == ROW_CFG) begin
                s_axis_tvalid <= 1'b0;
                drain();
                write_reg(r.addr, r.data);
            end else begin
                send_reading(r.ok, r.mx, r.my, r.typed, r.want);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            mode = ph / 2;
            snd_idle = (mode == 0) ? 17 : (mode == 1) ? 77 : 0;
            rcv_idle = (mode == 0) ? 77 : (mode == 1) ? 17 : 0;
            s_axis_tvalid <= 1'b0;
            drain();
            write_reg(CFG_OFFSET_X, (ph == 5) ? 16'h8000 : 16'($urandom_range(65535)));
            write_reg(CFG_OFFSET_Y, (ph == 5) ? 16'h7fff : 16'($urandom_range(65535)));
            write_reg(CFG_SCALE_X, (ph == 4) ? 16'd0 : 16'($urandom_range(65535)));
            write_reg(CFG_SCALE_Y, (ph == 4) ? 16'd65535 : 16'($urandom_range(65535)));
            write_reg(CFG_HEADING_OFFSET, (ph == 3) ? 16'sd23039 : (ph == 2) ? -16'sd23039
                                          : 16'($urandom_range(65535)));
            write_reg(CFG_FILTER_ALPHA, (ph == 1) ? 16'd256 : 16'($urandom_range(511)));
            write_reg(CFG_POSITION_BOOT, (ph == 0) ? 16'd23040 : 16'($urandom_range(32767)));
            for (int k = 0; k < 255; k++) begin
                if (ph == 1 && k == 100) begin
                    s_axis_tvalid <= 1'b0;
                    while (heading_q.size() != 0) @(posedge i_clk);
                end
                send_reading($urandom_range(9) != 0, 16'($urandom_range(65535)),
                             16'($urandom_range(65535)), 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;
        drain();

        $display("covered %0d readings, %0d results, %0d register writes in 6 settings",
                 n_items, n_results, n_cfg);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> sim.f
src/chft_pkg.sv
src/chft_mul.sv
src/chft_cordic.sv
src/compass_heading_filter_and_turn_tracker_unit.sv
tb/tb_top.sv
